FILE: hdl/tctt_pkg.sv
package tctt_pkg;

  localparam int TableDepth = 64;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CountW     = 7;

  typedef enum logic [1:0] {
    FUNC_NEW   = 2'd0,
    FUNC_TRACK = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    RSN_MATCHED  = 3'd0,
    RSN_NOMATCH  = 3'd1,
    RSN_ADDED    = 3'd2,
    RSN_FULL     = 3'd3,
    RSN_NOT_SYN  = 3'd4
  } reason_t;

  localparam logic [2:0] ST_WAIT   = 3'd0;
  localparam logic [2:0] ST_SYN    = 3'd1;
  localparam logic [2:0] ST_SYNACK = 3'd2;
  localparam logic [2:0] ST_EST    = 3'd3;
  localparam logic [2:0] ST_FIN1   = 3'd4;
  localparam logic [2:0] ST_FIN2   = 3'd5;

  localparam logic [1:0] KIND_PLAIN = 2'd0;

  typedef struct packed {
    logic [31:0] ca;
    logic [15:0] cp;
    logic [31:0] sa;
    logic [15:0] sp;
    logic [2:0]  st;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_RD,
    S_CMP,
    S_EXEC,
    S_WR2,
    S_OUT
  } fsm_t;

  typedef struct packed {
    logic capture;
    logic finish;
    logic start;
    logic rd;
    logic cmp;
    logic exec;
    logic wr2;
  } cmd_t;

  typedef struct packed {
    logic direct;
    logic hit;
    logic last;
    logic need_wr2;
  } sts_t;

endpackage

FILE: hdl/tcp_connection_tracking_table_top.sv
// Flow: the input transfer is captured in S_IDLE and decoded in S_DEC; a clear or an unused
// function code goes straight to S_OUT, which raises out_tvalid. A lookup scans the 64-row
// entry memory row by row, each row through S_RD (read) then S_CMP (compare); a hit stops the
// scan early, and S_EXEC (and S_WR2 for a second row) write back before S_OUT. One item is in
// flight: the next is taken only in S_IDLE, after the result transfer. Reset (rst_n low,
// synchronous) empties the table, zeroes the count and proxy address.
module tcp_connection_tracking_table_top
  import tctt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // sa[31:0] sp[47:32] da[79:48] dp[95:80] syn[96] fin[97] rst[98]
  // real_sa[130:99] real_sp[146:131], zero pad above
  input  logic [151:0] in_tdata,
  // func[1:0] connection_kind[3:2]
  input  logic [3:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // accept[0] reason[3:1] entries_in_use[10:4], zero pad above
  output logic [15:0]  out_tdata
);

  cmd_t              cmd;
  sts_t              sts;
  logic              res_accept;
  logic [2:0]        res_reason;
  logic [CountW-1:0] res_count;

  // Sequencer: accept, scan the table (lookups only), write back, hold the result until taken
  tctt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Entry memory, valid bits, count and the per-row state machine
  tctt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_user    (in_tuser),
    .in_data    (in_tdata[146:0]),
    .cmd        (cmd),
    .sts        (sts),
    .res_accept (res_accept),
    .res_reason (res_reason),
    .res_count  (res_count)
  );

  // Pack the result, pad to whole bytes
  assign out_tdata = {5'd0, res_count, res_reason, res_accept};

endmodule

FILE: hdl/tctt_ctrl.sv
module tctt_ctrl
  import tctt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.direct) begin
          cmd.finish = 1'b1;
          state_nxt  = S_OUT;
        end else begin
          cmd.start = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = (sts.hit || sts.last) ? S_EXEC : S_RD;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_wr2 ? S_WR2 : S_OUT;
      end
      S_WR2: begin
        cmd.wr2   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: hdl/tctt_dp.sv
module tctt_dp
  import tctt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  input  logic [3:0]        in_user,
  input  logic [146:0]      in_data,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              res_accept,
  output logic [2:0]        res_reason,
  output logic [CountW-1:0] res_count
);

  entry_t             mem [TableDepth];
  entry_t             rd_r;
  logic [TableDepth-1:0] valid_r;
  logic [CountW-1:0]  count_r;
  logic [31:0]        proxy_r;

  func_t              func_r;
  logic [1:0]         kind_r;
  logic [31:0]        sa_r, da_r, rsa_r;
  logic [15:0]        sp_r, dp_r, rsp_r;
  logic               syn_r, fin_r, rst_r;

  logic [IdxW-1:0]    idx_r, fa_r, fb_r;
  logic               fa_ok_r, fb_ok_r, hit_r;
  logic               acc_r;
  reason_t            reason_r;

  logic               tuple_hit, row_hit, client;
  logic               acc_nxt, wr_en, drop, add_a;
  reason_t            reason_nxt;
  entry_t             wr_data;
  logic [IdxW-1:0]    wr_addr;

  assign tuple_hit = (sa_r == rd_r.ca && sp_r == rd_r.cp && da_r == rd_r.sa && dp_r == rd_r.sp)
                  || (sa_r == rd_r.sa && sp_r == rd_r.sp && da_r == rd_r.ca && dp_r == rd_r.cp);
  assign row_hit   = valid_r[idx_r] && tuple_hit;
  assign client    = (sa_r == rd_r.ca);

  assign sts.direct   = (func_r == FUNC_CLEAR) || (func_r == FUNC_NONE);
  assign sts.hit      = row_hit;
  assign sts.last     = (idx_r == IdxW'(TableDepth - 1));
  assign sts.need_wr2 = (func_r == FUNC_NEW) && !hit_r && fa_ok_r && fb_ok_r
                     && (kind_r != KIND_PLAIN);

  // Work out the verdict and the write-back for the matched or free row
  always_comb begin
    acc_nxt    = 1'b0;
    reason_nxt = RSN_NOMATCH;
    wr_en      = 1'b0;
    drop       = 1'b0;
    add_a      = 1'b0;
    wr_data    = rd_r;
    wr_addr    = idx_r;
    if (func_r == FUNC_NEW) begin
      if (hit_r) begin
        acc_nxt    = (rd_r.st == ST_SYN);
        reason_nxt = (rd_r.st == ST_SYN) ? RSN_MATCHED : RSN_NOT_SYN;
      end else if (!fa_ok_r || ((kind_r != KIND_PLAIN) && !fb_ok_r)) begin
        reason_nxt = RSN_FULL;
      end else begin
        acc_nxt    = 1'b1;
        reason_nxt = RSN_ADDED;
        wr_en      = 1'b1;
        add_a      = 1'b1;
        wr_addr    = fa_r;
        wr_data    = '{ca: sa_r, cp: sp_r, sa: da_r, sp: dp_r, st: ST_SYN};
      end
    end else if (hit_r) begin
      wr_en = 1'b1;
      drop  = rst_r;
      case (rd_r.st)
        ST_WAIT: begin
          acc_nxt = client && syn_r;
          if (client && syn_r) wr_data.st = ST_SYN;
        end
        ST_SYN: begin
          acc_nxt = syn_r;
          if (!client && syn_r) wr_data.st = ST_SYNACK;
        end
        ST_SYNACK: begin
          acc_nxt = client;
          if (client) wr_data.st = ST_EST;
        end
        ST_EST: begin
          acc_nxt = 1'b1;
          if (fin_r) wr_data = '{ca: sa_r, cp: sp_r, sa: da_r, sp: dp_r, st: ST_FIN1};
        end
        ST_FIN1: begin
          acc_nxt = fin_r;
          if (!client && fin_r) wr_data.st = ST_FIN2;
        end
        ST_FIN2: begin
          acc_nxt = client;
          if (client) drop = 1'b1;
        end
        default: acc_nxt = 1'b0;
      endcase
      reason_nxt = acc_nxt ? RSN_MATCHED : RSN_NOMATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_r <= mem[idx_r];
    end
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= wr_data;
    end else if (cmd.wr2) begin
      mem[fb_r] <= '{ca: proxy_r, cp: 16'd0, sa: rsa_r, sp: rsp_r, st: ST_WAIT};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= func_t'(in_user[1:0]);
      kind_r <= in_user[3:2];
      sa_r   <= in_data[31:0];
      sp_r   <= in_data[47:32];
      da_r   <= in_data[79:48];
      dp_r   <= in_data[95:80];
      syn_r  <= in_data[96];
      fin_r  <= in_data[97];
      rst_r  <= in_data[98];
      rsa_r  <= in_data[130:99];
      rsp_r  <= in_data[146:131];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      count_r  <= '0;
      proxy_r  <= '0;
      idx_r    <= '0;
      fa_r     <= '0;
      fb_r     <= '0;
      fa_ok_r  <= 1'b0;
      fb_ok_r  <= 1'b0;
      hit_r    <= 1'b0;
      acc_r    <= 1'b0;
      reason_r <= RSN_NOMATCH;
    end else begin
      if (cfg_we) begin
        proxy_r <= cfg_wdata;
      end
      if (cmd.finish) begin
        acc_r <= 1'b0;
        if (func_r == FUNC_CLEAR) begin
          valid_r  <= '0;
          count_r  <= '0;
          reason_r <= RSN_MATCHED;
        end else begin
          reason_r <= RSN_NOMATCH;
        end
      end
      if (cmd.start) begin
        idx_r   <= '0;
        fa_ok_r <= 1'b0;
        fb_ok_r <= 1'b0;
        hit_r   <= 1'b0;
      end
      if (cmd.cmp) begin
        hit_r <= row_hit;
        if (!valid_r[idx_r]) begin
          if (!fa_ok_r) begin
            fa_r    <= idx_r;
            fa_ok_r <= 1'b1;
          end else if (!fb_ok_r) begin
            fb_r    <= idx_r;
            fb_ok_r <= 1'b1;
          end
        end
        if (!row_hit && !sts.last) begin
          idx_r <= idx_r + 1'b1;
        end
      end
      if (cmd.exec) begin
        acc_r    <= acc_nxt;
        reason_r <= reason_nxt;
        if (add_a) begin
          valid_r[fa_r] <= 1'b1;
          count_r       <= count_r + 1'b1;
        end else if (drop && valid_r[idx_r]) begin
          valid_r[idx_r] <= 1'b0;
          count_r        <= count_r - 1'b1;
        end
      end
      if (cmd.wr2) begin
        valid_r[fb_r] <= 1'b1;
        count_r       <= count_r + 1'b1;
      end
    end
  end

  assign res_accept = acc_r;
  assign res_reason = reason_r;
  assign res_count  = count_r;

endmodule

FILE: hdl/tctt_checker.sv
module tctt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[10:4] <= 7'd64))
    else $error("entry count out of range");

  a_accept_reason: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (out_tdata[3:1] == 3'd0 || out_tdata[3:1] == 3'd2))
    else $error("accept with a drop reason");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind tcp_connection_tracking_table_top tctt_checker u_tctt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
